// ----- rtl/core/ppfd_pkg.sv -----
// Package for the pulse-pair frame decoder: widths, register indexes, status codes
// and the frame check and compare functions. Used by every RTL file of the block.
`default_nettype none

package ppfd_pkg;

  localparam int TIME_W    = 16;
  localparam int PCT_W     = 7;
  localparam int COUNT_W   = 7;
  localparam int FRAME_W   = 64;
  localparam int ID_W      = 14;
  localparam int ID_LSB    = 40;
  localparam int CSUM_LSB  = 48;
  localparam int PAR_LSB   = 16;
  localparam int PAR_W     = 32;
  localparam int BYTE_W    = 8;
  localparam int SUM_BYTES = 6;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 16;

  localparam int END_GAP_MULT = 3;
  localparam int LONG3_W      = TIME_W + 2;
  localparam int PCT_SCALE    = 100;

  // Division by the percent scale is done as a multiply by a rounded-up reciprocal.
  localparam int PROD_W    = TIME_W + PCT_W;
  localparam int DIV_SHIFT = PROD_W + 7;
  localparam int RECIP_W   = DIV_SHIFT - 6;
  localparam int QUOT_W    = PROD_W - 6;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) / 64'(PCT_SCALE)) + 64'd1);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [COUNT_W-1:0] MAX_BITS = COUNT_W'(FRAME_W);

  localparam int SETTLE_W = 2;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(3);

  localparam logic [TIME_W-1:0]  RST_SHORT = TIME_W'(200);
  localparam logic [TIME_W-1:0]  RST_LONG  = TIME_W'(400);
  localparam logic [TIME_W-1:0]  RST_TOL   = TIME_W'(0);
  localparam logic [PCT_W-1:0]   RST_PCT   = PCT_W'(25);
  localparam logic [COUNT_W-1:0] RST_NEED  = COUNT_W'(56);

  typedef enum logic [IDX_W-1:0] {
    REG_SHORT_TIME = 3'd0,
    REG_LONG_TIME  = 3'd1,
    REG_TOL_ABS    = 3'd2,
    REG_TOL_PCT    = 3'd3,
    REG_BITS_NEED  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_PARITY   = 2'd3
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0]  short_time;
    logic [TIME_W-1:0]  long_time;
    logic [LONG3_W-1:0] end_gap;
    logic [TIME_W-1:0]  tol;
    logic [COUNT_W-1:0] need;
    logic               busy;
  } cfg_t;

  function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic status_e frame_status(input logic [FRAME_W-1:0] sr);
    logic [BYTE_W-1:0] sum;
    sum = '0;
    for (int k = 0; k < SUM_BYTES; k++) begin
      sum = sum + sr[CSUM_LSB + BYTE_W - 1 - BYTE_W*k -: BYTE_W];
    end
    if (sum != sr[BYTE_W-1:0]) begin
      return ST_CHECKSUM;
    end
    if (^sr[PAR_LSB +: PAR_W]) begin
      return ST_PARITY;
    end
    return ST_OK;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ppfd_cfg.sv -----
// Configuration registers of the pulse-pair frame decoder and the derived tolerance.
// Depends on ppfd_pkg.
`default_nettype none

module ppfd_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [ppfd_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [ppfd_pkg::CFG_W-1:0]   cfg_data_i,
  output ppfd_pkg::cfg_t                    cfg_o
);

  logic [ppfd_pkg::TIME_W-1:0]   short_q, long_q, tol_abs_q, tol_q;
  logic [ppfd_pkg::PCT_W-1:0]    tol_pct_q;
  logic [ppfd_pkg::COUNT_W-1:0]  bits_need_q, need_q;
  logic [ppfd_pkg::LONG3_W-1:0]  end_gap_q;
  logic [ppfd_pkg::PROD_W-1:0]   prod_q;
  logic [ppfd_pkg::QUOT_W-1:0]   quot_q;
  logic [ppfd_pkg::SETTLE_W-1:0] settle_q;
  logic [ppfd_pkg::PROD_W+ppfd_pkg::RECIP_W-1:0] recip_prod;
  logic [ppfd_pkg::TIME_W-1:0]   tol_pct_sat;

  assign recip_prod = ppfd_pkg::PROD_W'(prod_q) * ppfd_pkg::RECIP;
  assign tol_pct_sat = (quot_q > ppfd_pkg::QUOT_W'(ppfd_pkg::TIME_MAX)) ?
                       ppfd_pkg::TIME_MAX : ppfd_pkg::TIME_W'(quot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q     <= ppfd_pkg::RST_SHORT;
      long_q      <= ppfd_pkg::RST_LONG;
      tol_abs_q   <= ppfd_pkg::RST_TOL;
      tol_pct_q   <= ppfd_pkg::RST_PCT;
      bits_need_q <= ppfd_pkg::RST_NEED;
      settle_q    <= ppfd_pkg::SETTLE_CYCLES;
    end else if (cfg_valid_i) begin
      settle_q <= ppfd_pkg::SETTLE_CYCLES;
      unique case (ppfd_pkg::cfg_reg_e'(cfg_index_i))
        ppfd_pkg::REG_SHORT_TIME: short_q     <= cfg_data_i[ppfd_pkg::TIME_W-1:0];
        ppfd_pkg::REG_LONG_TIME:  long_q      <= cfg_data_i[ppfd_pkg::TIME_W-1:0];
        ppfd_pkg::REG_TOL_ABS:    tol_abs_q   <= cfg_data_i[ppfd_pkg::TIME_W-1:0];
        ppfd_pkg::REG_TOL_PCT:    tol_pct_q   <= cfg_data_i[ppfd_pkg::PCT_W-1:0];
        ppfd_pkg::REG_BITS_NEED:  bits_need_q <= cfg_data_i[ppfd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  // After a write the input is held off while the derived registers settle.
  always_ff @(posedge clk_i) begin
    prod_q    <= ppfd_pkg::PROD_W'(short_q) * ppfd_pkg::PROD_W'(tol_pct_q);
    quot_q    <= recip_prod[ppfd_pkg::DIV_SHIFT +: ppfd_pkg::QUOT_W];
    tol_q     <= (tol_abs_q != '0) ? tol_abs_q : tol_pct_sat;
    end_gap_q <= ppfd_pkg::LONG3_W'(long_q) * ppfd_pkg::LONG3_W'(ppfd_pkg::END_GAP_MULT);
    need_q    <= (bits_need_q > ppfd_pkg::MAX_BITS) ? ppfd_pkg::MAX_BITS : bits_need_q;
  end

  always_comb begin
    cfg_o.short_time = short_q;
    cfg_o.long_time  = long_q;
    cfg_o.end_gap    = end_gap_q;
    cfg_o.tol        = tol_q;
    cfg_o.need       = need_q;
    cfg_o.busy       = (settle_q != '0);
  end

endmodule

`default_nettype wire

// ----- rtl/core/pwm_pulse_pair_frame_decoder.sv -----
// Top level of the pulse-pair frame decoder: input register, pair classing, frame
// state and result register. Depends on ppfd_pkg and ppfd_cfg.
//
// The decoder takes one pulse pair per clock cycle while in_stall_o is low and shows
// its result, if it has one, from a result register fed from the input register; a
// result waiting on a stalled output stalls the input while a pair waits in the
// input register. The rate is set by the frame shift register, which classes a pair,
// shifts in its bit and checks the frame before the state is registered, so that the
// next pair sees the updated state. After reset and every configuration write the
// input stalls while the product, quotient and tolerance registers derive the tolerance.
`default_nettype none

module pwm_pulse_pair_frame_decoder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [ppfd_pkg::IDX_W-1:0]     cfg_index_i,
  input  wire logic [ppfd_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [ppfd_pkg::TIME_W-1:0]    high_time_i,
  input  wire logic [ppfd_pkg::TIME_W-1:0]    low_time_i,
  input  wire logic                           first_pair_i,
  input  wire logic                           last_pair_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [1:0]                     status_o,
  output      logic [ppfd_pkg::FRAME_W-1:0]   frame_bits_o,
  output      logic [ppfd_pkg::COUNT_W-1:0]   bit_count_o,
  output      logic [ppfd_pkg::ID_W-1:0]      sensor_id_o
);

  ppfd_pkg::cfg_t cfg;

  ppfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cfg_ready_o = 1'b1;

  logic                          in_valid_q;
  logic [ppfd_pkg::TIME_W-1:0]   high_q, low_q;
  logic                          first_q, last_q;
  logic [ppfd_pkg::FRAME_W-1:0]  sr_q, sr_d;
  logic [ppfd_pkg::COUNT_W-1:0]  bits_q, bits_d;
  logic                          done_q, done_d;
  logic                          out_valid_q;
  ppfd_pkg::status_e             status_q, status_d;
  logic [ppfd_pkg::FRAME_W-1:0]  frame_q;
  logic [ppfd_pkg::COUNT_W-1:0]  count_q;

  logic out_free, fire, in_accept, emit;
  logic [ppfd_pkg::FRAME_W-1:0] base_sr, new_sr;
  logic [ppfd_pkg::COUNT_W-1:0] base_bits, new_bits;
  logic base_done, full_before, matched, bit_val;
  logic hi_long, hi_short, lo_long, lo_short, lo_end;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = cfg.busy || (in_valid_q && !out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign hi_long  = ppfd_pkg::abs_diff(high_q, cfg.long_time)  < cfg.tol;
  assign hi_short = ppfd_pkg::abs_diff(high_q, cfg.short_time) < cfg.tol;
  assign lo_long  = ppfd_pkg::abs_diff(low_q, cfg.long_time)   < cfg.tol;
  assign lo_short = ppfd_pkg::abs_diff(low_q, cfg.short_time)  < cfg.tol;
  assign lo_end   = ppfd_pkg::LONG3_W'(low_q) > cfg.end_gap;

  always_comb begin
    base_sr   = first_q ? '0 : sr_q;
    base_bits = first_q ? '0 : bits_q;
    base_done = first_q ? 1'b0 : done_q;
    full_before = (base_bits >= cfg.need);

    matched = 1'b1;
    bit_val = 1'b0;
    priority if (hi_long && lo_short) begin
      bit_val = 1'b1;
    end else if (hi_short && lo_long) begin
      bit_val = 1'b0;
    end else if (hi_short && lo_end) begin
      bit_val = 1'b0;
    end else if (hi_long && lo_end) begin
      bit_val = 1'b1;
    end else begin
      matched = 1'b0;
    end

    new_sr   = {base_sr[ppfd_pkg::FRAME_W-2:0], bit_val};
    new_bits = base_bits + 1'b1;

    sr_d     = base_sr;
    bits_d   = base_bits;
    emit     = 1'b0;
    status_d = ppfd_pkg::ST_MISMATCH;
    priority if (base_done) begin
      emit = 1'b0;
    end else if (full_before) begin
      emit     = 1'b1;
      status_d = ppfd_pkg::frame_status(base_sr);
    end else if (!matched) begin
      emit = 1'b1;
    end else begin
      sr_d   = new_sr;
      bits_d = new_bits;
      if (new_bits >= cfg.need) begin
        emit     = 1'b1;
        status_d = ppfd_pkg::frame_status(new_sr);
      end else if (last_q) begin
        emit = 1'b1;
      end
    end
    done_d = base_done || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sr_q        <= '0;
      bits_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        sr_q        <= sr_d;
        bits_q      <= bits_d;
        done_q      <= done_d;
        out_valid_q <= emit;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      high_q  <= high_time_i;
      low_q   <= low_time_i;
      first_q <= first_pair_i;
      last_q  <= last_pair_i;
    end
    if (fire && emit) begin
      status_q <= status_d;
      frame_q  <= sr_d;
      count_q  <= bits_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign frame_bits_o = frame_q;
  assign bit_count_o  = count_q;
  assign sensor_id_o  = frame_q[ppfd_pkg::ID_LSB +: ppfd_pkg::ID_W];

endmodule

`default_nettype wire

// ----- rtl/core/ppfd_checker.sv -----
// Port-level checks for the pulse-pair frame decoder, and the bind that attaches them
// to the top level. Depends on ppfd_pkg and the top level's ports.
`default_nettype none

module ppfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [63:0] frame_bits_o,
  input wire logic [6:0]  bit_count_o,
  input wire logic [13:0] sensor_id_o
);

  logic [7:0] byte_sum;

  assign byte_sum = frame_bits_o[55:48] + frame_bits_o[47:40] + frame_bits_o[39:32] +
                    frame_bits_o[31:24] + frame_bits_o[23:16] + frame_bits_o[15:8];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_bits_o) &&
                                   $stable(status_o) && $stable(bit_count_o))
    else $error("Result changed while stalled.");

  a_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sensor_id_o == frame_bits_o[53:40])
    else $error("Sensor id does not match the frame bits.");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bit_count_o <= 7'd64)
    else $error("Bit count above the frame width.");

  a_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ppfd_pkg::ST_OK |-> byte_sum == frame_bits_o[7:0] &&
                                                   !(^frame_bits_o[47:16]))
    else $error("Frame reported good with a bad checksum or parity.");

endmodule

bind pwm_pulse_pair_frame_decoder ppfd_checker u_ppfd_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the pulse-pair frame decoder. Directed and random pulse
// pairs under several register settings are checked against a predictor kept here.
// Depends on ppfd_pkg and pwm_pulse_pair_frame_decoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppfd_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_WAIT    = 8;

  typedef struct {
    status_e            status;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
    logic [ID_W-1:0]    id;
  } decoded_frame_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  cfg_reg_e           cfg_index_i = REG_SHORT_TIME;
  logic [CFG_W-1:0]   cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [TIME_W-1:0]  high_time_i = '0;
  logic [TIME_W-1:0]  low_time_i  = '0;
  logic               first_pair_i = 1'b0;
  logic               last_pair_i  = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [FRAME_W-1:0] frame_bits_o;
  logic [COUNT_W-1:0] bit_count_o;
  logic [ID_W-1:0]    sensor_id_o;

  logic [TIME_W-1:0]  nom_short = RST_SHORT;
  logic [TIME_W-1:0]  nom_long  = RST_LONG;
  logic [TIME_W-1:0]  tol_abs   = RST_TOL;
  logic [PCT_W-1:0]   tol_pct   = RST_PCT;
  logic [COUNT_W-1:0] bits_need = RST_NEED;
  logic [FRAME_W-1:0] frame_shift  = '0;
  logic [COUNT_W-1:0] frame_count  = '0;
  bit                 frame_closed = 1'b0;
  decoded_frame_t     pending_frames[$];

  int failures    = 0;
  int gap_pct     = 20;
  int stall_pct   = 20;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;

  pwm_pulse_pair_frame_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .high_time_i (high_time_i),
    .low_time_i  (low_time_i),
    .first_pair_i(first_pair_i),
    .last_pair_i (last_pair_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .frame_bits_o(frame_bits_o),
    .bit_count_o (bit_count_o),
    .sensor_id_o (sensor_id_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int abs_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int match_window();
    int prod;
    if (tol_abs != 0) begin
      return int'(tol_abs);
    end
    prod = (int'(nom_short) * int'(tol_pct)) / 100;
    return (prod > int'(TIME_MAX)) ? int'(TIME_MAX) : prod;
  endfunction

  function automatic status_e frame_verdict(logic [FRAME_W-1:0] word);
    logic [7:0] total;
    total = '0;
    for (int k = 0; k < 6; k++) begin
      total += word[55 - 8*k -: 8];
    end
    if (total != word[7:0]) begin
      return ST_CHECKSUM;
    end
    if (^word[47:16]) begin
      return ST_PARITY;
    end
    return ST_OK;
  endfunction

  function automatic void close_frame(status_e st);
    decoded_frame_t r;
    r.status = st;
    r.frame  = frame_shift;
    r.count  = frame_count;
    r.id     = frame_shift[53:40];
    pending_frames.push_back(r);
    frame_closed = 1'b1;
  endfunction

  function automatic void decode_pair(logic [TIME_W-1:0] hi, logic [TIME_W-1:0] lo,
                                      bit first, bit last);
    int win;
    int need;
    bit hi_long, hi_short, lo_long, lo_short, lo_end, one;
    need = (bits_need > 64) ? 64 : int'(bits_need);
    if (first) begin
      frame_shift  = '0;
      frame_count  = '0;
      frame_closed = 1'b0;
    end
    if (frame_closed) begin
      return;
    end
    if (frame_count >= need) begin
      close_frame(frame_verdict(frame_shift));
      return;
    end
    win      = match_window();
    hi_long  = abs_gap(int'(hi), int'(nom_long)) < win;
    hi_short = abs_gap(int'(hi), int'(nom_short)) < win;
    lo_long  = abs_gap(int'(lo), int'(nom_long)) < win;
    lo_short = abs_gap(int'(lo), int'(nom_short)) < win;
    lo_end   = int'(lo) > 3 * int'(nom_long);
    if (hi_long && lo_short) begin
      one = 1'b1;
    end else if (hi_short && lo_long) begin
      one = 1'b0;
    end else if (hi_short && lo_end) begin
      one = 1'b0;
    end else if (hi_long && lo_end) begin
      one = 1'b1;
    end else begin
      close_frame(ST_MISMATCH);
      return;
    end
    frame_shift = {frame_shift[FRAME_W-2:0], one};
    frame_count++;
    if (frame_count >= need) begin
      close_frame(frame_verdict(frame_shift));
    end else if (last) begin
      close_frame(ST_MISMATCH);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    decoded_frame_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_frames.size() == 0) begin
        $error("result with no item pending: status %0d, frame %h", status_o, frame_bits_o);
        failures++;
      end else begin
        want = pending_frames.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          failures++;
        end
        if (frame_bits_o !== want.frame) begin
          $error("frame_bits: expected %h, actual %h", want.frame, frame_bits_o);
          failures++;
        end
        if (bit_count_o !== want.count) begin
          $error("bit_count: expected %0d, actual %0d", want.count, bit_count_o);
          failures++;
        end
        if (sensor_id_o !== want.id) begin
          $error("sensor_id: expected %h, actual %h", want.id, sensor_id_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** pwm_pulse_pair_frame_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(19, 1)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_pair(logic [TIME_W-1:0] hi, logic [TIME_W-1:0] lo, bit first, bit last);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    high_time_i  <= hi;
    low_time_i   <= lo;
    first_pair_i <= first;
    last_pair_i  <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decode_pair(hi, lo, first, last);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_SHORT_TIME: nom_short = TIME_W'(value);
      REG_LONG_TIME:  nom_long  = TIME_W'(value);
      REG_TOL_ABS:    tol_abs   = TIME_W'(value);
      REG_TOL_PCT:    tol_pct   = PCT_W'(value);
      REG_BITS_NEED:  bits_need = COUNT_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_setup(int short_t, int long_t, int abs_t, int pct, int need);
    settle();
    write_reg(REG_SHORT_TIME, short_t);
    write_reg(REG_LONG_TIME, long_t);
    write_reg(REG_TOL_ABS, abs_t);
    write_reg(REG_TOL_PCT, pct);
    write_reg(REG_BITS_NEED, need);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] near(logic [TIME_W-1:0] nominal);
    int win;
    int v;
    win = match_window();
    if (win <= 0) begin
      return nominal;
    end
    v = int'(nominal) + int'($urandom_range(2 * (win - 1))) - (win - 1);
    return (v < 0) ? '0 : (v > 65535) ? '1 : TIME_W'(v);
  endfunction

  function automatic logic [TIME_W-1:0] end_gap();
    int floor3;
    floor3 = 3 * int'(nom_long) + 1;
    if (floor3 > 65535) begin
      return '1;
    end
    return TIME_W'($urandom_range(65535, floor3));
  endfunction

  function automatic logic [FRAME_W-1:0] sensor_word();
    logic [FRAME_W-1:0] w;
    logic [7:0]         total;
    int                 kind;
    w    = {$urandom, $urandom};
    kind = $urandom_range(3);
    if (^w[47:16]) begin
      w[16] = ~w[16];
    end
    if (kind == 2) begin
      w[20] = ~w[20];
    end
    total = '0;
    for (int k = 0; k < 6; k++) begin
      total += w[55 - 8*k -: 8];
    end
    w[7:0] = (kind == 1) ? ~total : total;
    return w;
  endfunction

  task automatic send_bit(bit one, bit end_style, bit first, bit last);
    logic [TIME_W-1:0] hi;
    logic [TIME_W-1:0] lo;
    hi = one ? near(nom_long) : near(nom_short);
    lo = end_style ? end_gap() : (one ? near(nom_short) : near(nom_long));
    send_pair(hi, lo, first, last);
  endtask

  task automatic send_capture(logic [FRAME_W-1:0] word, int nbits, bit with_last, int bad_at);
    for (int i = nbits - 1; i >= 0; i--) begin
      if (i == bad_at) begin
        send_pair(TIME_W'($urandom), TIME_W'($urandom), i == nbits - 1, 1'b0);
      end else begin
        send_bit(word[i], (i == 0) && ($urandom_range(1) != 0), i == nbits - 1,
                 with_last && (i == 0));
      end
    end
  endtask

  task automatic run_traffic(int n_items);
    int sent;
    int need;
    int pick;
    int cut;
    sent = 0;
    while (sent < n_items) begin
      need = (bits_need > 64) ? 64 : int'(bits_need);
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_capture(sensor_word(), need, 1'($urandom_range(1)), -1);
        sent += need;
      end else if (pick < 80) begin
        cut = $urandom_range(need - 1);
        send_capture(sensor_word(), need, 1'($urandom_range(1)), cut);
        sent += need;
      end else if (pick < 88 && need > 1) begin
        cut = $urandom_range(need - 1, 1);
        send_capture(sensor_word(), cut, 1'b1, -1);
        sent += cut;
      end else begin
        send_pair(TIME_W'($urandom), TIME_W'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        sent++;
      end
      if ($urandom_range(3) == 0) begin
        send_bit(1'($urandom_range(1)), 1'b0, 1'b0, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic test_before_first();
    send_pair(16'd400, 16'd200, 1'b0, 1'b0);
    send_pair(16'd200, 16'd400, 1'b0, 1'b0);
    send_pair(16'd400, 16'hFFFF, 1'b0, 1'b1);
    send_pair(16'd0, 16'd0, 1'b0, 1'b0);
  endtask

  task automatic test_field_extremes();
    send_pair(16'hFFFF, 16'h0000, 1'b1, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b1, 1'b1);
  endtask

  task automatic test_end_bits();
    apply_setup(200, 400, 0, 25, 4);
    send_pair(16'd200, 16'd400, 1'b1, 1'b0);
    send_pair(16'd400, 16'd200, 1'b0, 1'b0);
    send_pair(16'd200, 16'd1201, 1'b0, 1'b0);
    send_pair(16'd400, 16'hFFFF, 1'b0, 1'b0);
    send_pair(16'd400, 16'd200, 1'b0, 1'b1);
  endtask

  task automatic test_count_lowered();
    apply_setup(200, 400, 0, 25, 56);
    for (int i = 0; i < 5; i++) begin
      send_bit(1'($urandom_range(1)), 1'b0, i == 0, 1'b0);
    end
    apply_setup(200, 400, 0, 25, 3);
    send_pair(16'd0, 16'd0, 1'b0, 1'b0);
  endtask

  task automatic test_tolerance_modes();
    apply_setup(300, 310, 50, 25, 1);
    send_pair(16'd305, 16'd305, 1'b1, 1'b0);
    apply_setup(65535, 1000, 0, 100, 1);
    send_pair(16'hFFFF, 16'd1000, 1'b1, 1'b0);
    apply_setup(200, 400, 0, 0, 1);
    send_pair(16'd200, 16'd400, 1'b1, 1'b0);
  endtask

  task automatic test_pressure();
    apply_setup(200, 400, 0, 25, 1);
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(4) == 0) begin
        send_pair(TIME_W'($urandom), TIME_W'($urandom), 1'b1, 1'($urandom_range(1)));
      end else begin
        send_bit(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, 1'b0);
      end
    end
    settle();
  endtask

  task automatic test_random_traffic();
    int s;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setup(200, 400, 0, 25, 56);
        1: apply_setup(1000, 2500, 300, 0, 56);
        2: apply_setup(100, 300, 40, 25, 64);
        3: apply_setup(200, 400, 0, 25, 1);
        4: begin
          s = $urandom_range(3000, 50);
          apply_setup(s, s * $urandom_range(3, 2), 0, $urandom_range(40, 10),
                      $urandom_range(64, 1));
        end
        5: apply_setup(65535, 0, 0, 100, 8);
        6: apply_setup(0, 65535, 65535, 0, 16);
        default: apply_setup(200, 400, 0, 25, 56);
      endcase
      gap_pct   = (p == 7) ? 0 : 10 * $urandom_range(3);
      stall_pct = (p == 7) ? 0 : 15 * $urandom_range(3);
      case (p)
        0, 1:    run_traffic(120);
        2:       run_traffic(100);
        3:       run_traffic(70);
        4:       run_traffic(100);
        5, 6:    run_traffic(50);
        default: run_traffic(150);
      endcase
    end
  endtask

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    test_before_first();
    test_field_extremes();
    test_end_bits();
    test_count_lowered();
    test_tolerance_modes();
    test_pressure();
    test_random_traffic();
    settle();
    if (failures == 0) begin
      $display("** pwm_pulse_pair_frame_decoder: PASSED **");
    end else begin
      $display("** pwm_pulse_pair_frame_decoder: FAILED **");
    end
    $finish;
  end

endmodule
